// ===== rtl/core/gsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg
// Types, sizes and address helpers for the gaussian statistics accumulator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  // store geometry
  localparam int STATES     = 256;
  localparam int STREAMS    = 4;
  localparam int COMPONENTS = 64;
  localparam int ELEMS      = STATES * STREAMS * COMPONENTS;
  localparam int COUNTS     = STATES * STREAMS;
  localparam int ELEM_AW    = $clog2(ELEMS);
  localparam int CNT_AW     = $clog2(COUNTS);

  // field widths
  localparam int STATE_W  = 8;
  localparam int STREAM_W = 2;
  localparam int COMP_W   = 6;
  localparam int VALUE_W  = 16;
  localparam int FRAC_W   = 8;
  localparam int SUM_W    = 64;
  localparam int COUNT_W  = 32;
  localparam int SQ_W     = 2 * (VALUE_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_STATE = 1'b1;

  // item functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ACCUM = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [STATE_W-1:0]         tied_state;
    logic [STATE_W-1:0]         ci_state;
    logic [STREAM_W-1:0]        stream_index;
    logic [COMP_W-1:0]          component_index;
    logic signed [VALUE_W-1:0]  feature_value;
    logic                       first_component;
    logic                       last_item;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] tied_sum;
    logic [COUNT_W-1:0]      tied_count;
    logic signed [SUM_W-1:0] ci_sum;
    logic [COUNT_W-1:0]      ci_count;
    logic                    ci_updated;
    logic                    last_result;
  } out_t;

  function automatic logic [ELEM_AW-1:0] elem_addr(input logic [STATE_W-1:0]  s,
                                                   input logic [STREAM_W-1:0] f,
                                                   input logic [COMP_W-1:0]   c);
    elem_addr = (ELEM_AW'(s) * ELEM_AW'(STREAMS) + ELEM_AW'(f)) * ELEM_AW'(COMPONENTS)
                + ELEM_AW'(c);
  endfunction

  function automatic logic [CNT_AW-1:0] cnt_addr(input logic [STATE_W-1:0]  s,
                                                 input logic [STREAM_W-1:0] f);
    cnt_addr = CNT_AW'(s) * CNT_AW'(STREAMS) + CNT_AW'(f);
  endfunction

endpackage

// ===== rtl/core/gsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read returns old data on a same-address write
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/gaussian_stats_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_stats_accumulator_unit
// Per-state mean / variance statistics accumulator over RAM-held sums.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i) takes load and
// accumulate transactions. A load writes the mean store in the accept cycle
// and produces no result; ready is high again on the next cycle.
// An accumulate reads sum, mean and count of the tied state, squares the
// deviation in variance mode, then adds with saturation and writes back.
// When the context-independent state differs, a second read-modify-write
// pass follows on the same RAMs.
// An accumulate passes through S_CALC and S_ADD (twice for two passes), then
// S_OUT, before out_valid_o rises; in_ready_o is high only in S_IDLE, so a
// new accumulate is taken only after the current one has left S_OUT.
// Result channel (out_valid_o / out_ready_i / out_data_o) is a register;
// a finished result is held there while the receiver stalls, and the next
// item may already be in flight; it waits only when both results collide.
// After reset the sum and count RAMs are cleared, one entry per cycle across
// all 65536 sum entries with in_ready_o low; config writes are taken anytime.
// ----------------------------------------------------------------------------
module gaussian_stats_accumulator_unit
  import gsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_ADD,
    S_OUT
  } state_e;

  state_e                    state_q;
  logic [ELEM_AW-1:0]        clr_q;
  logic                      mode_q;
  logic                      single_q;
  logic [STATE_W-1:0]        tied_q;
  logic [STATE_W-1:0]        ci_q;
  logic [STREAM_W-1:0]       strm_q;
  logic [COMP_W-1:0]         comp_q;
  logic signed [VALUE_W-1:0] x_q;
  logic                      first_q;
  logic                      diff_q;
  logic                      phase_q;
  logic [SQ_W-1:0]           sq_q;
  out_t                      res_q;
  out_t                      out_q;
  logic                      out_valid_q;

  // ram ports
  logic                      rd_en;
  logic [ELEM_AW-1:0]        rd_eaddr;
  logic [CNT_AW-1:0]         rd_caddr;
  logic                      sum_we;
  logic [ELEM_AW-1:0]        sum_waddr;
  logic [SUM_W-1:0]          sum_wdata;
  logic [SUM_W-1:0]          sum_rd;
  logic                      mean_we;
  logic [VALUE_W-1:0]        mean_rd;
  logic                      cnt_we;
  logic [CNT_AW-1:0]         cnt_waddr;
  logic [COUNT_W-1:0]        cnt_wdata;
  logic [COUNT_W-1:0]        cnt_rd;

  // input side
  logic                      accept;
  logic [STATE_W-1:0]        s_eff;
  logic [STATE_W-1:0]        ci_eff;
  logic                      in_range;
  logic                      ci_ok;
  logic                      start_accum;
  logic [ELEM_AW-1:0]        in_eaddr;
  logic [CNT_AW-1:0]         in_caddr;

  // current pass addresses
  logic [STATE_W-1:0]        cur_s;
  logic [ELEM_AW-1:0]        cur_eaddr;
  logic [CNT_AW-1:0]         cur_caddr;
  logic [ELEM_AW-1:0]        ci_eaddr;
  logic [CNT_AW-1:0]         ci_caddr;

  // datapath
  logic signed [VALUE_W:0]   diff;
  logic signed [SQ_W-1:0]    sq_d;
  logic [SQ_W-1:0]           sq_rnd;
  logic [SUM_W-1:0]          addend;
  logic [SUM_W-1:0]          sum_raw;
  logic                      sum_ovf;
  logic [SUM_W-1:0]          sum_new;
  logic                      cnt_max;
  logic                      cnt_bump;
  logic [COUNT_W-1:0]        cnt_new;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign s_eff    = single_q ? '0 : in_data_i.tied_state;
  assign ci_eff   = single_q ? '0 : in_data_i.ci_state;
  assign in_range = (32'(s_eff) < STATES) && (32'(in_data_i.stream_index) < STREAMS) &&
                    (32'(in_data_i.component_index) < COMPONENTS);
  assign ci_ok    = (32'(ci_eff) < STATES);
  assign start_accum = accept && in_range && ci_ok && (in_data_i.func == FUNC_ACCUM);
  assign in_eaddr = elem_addr(s_eff, in_data_i.stream_index, in_data_i.component_index);
  assign in_caddr = cnt_addr(s_eff, in_data_i.stream_index);

  assign cur_s     = phase_q ? ci_q : tied_q;
  assign cur_eaddr = elem_addr(cur_s, strm_q, comp_q);
  assign cur_caddr = cnt_addr(cur_s, strm_q);
  assign ci_eaddr  = elem_addr(ci_q, strm_q, comp_q);
  assign ci_caddr  = cnt_addr(ci_q, strm_q);

  // deviation squared, registered before the add
  assign diff = {x_q[VALUE_W-1], x_q} - {mean_rd[VALUE_W-1], mean_rd};
  assign sq_d = diff * diff;

  // round q.16 square to q.8
  assign sq_rnd  = sq_q + SQ_W'(1 << (FRAC_W - 1));
  assign addend  = mode_q ? SUM_W'(sq_rnd[SQ_W-1:FRAC_W])
                          : {{(SUM_W-VALUE_W){x_q[VALUE_W-1]}}, x_q};
  assign sum_raw = sum_rd + addend;
  assign sum_ovf = (sum_rd[SUM_W-1] == addend[SUM_W-1]) &&
                   (sum_raw[SUM_W-1] != sum_rd[SUM_W-1]);
  assign sum_new = sum_ovf ? (sum_rd[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}})
                           : sum_raw;
  assign cnt_max  = &cnt_rd;
  assign cnt_bump = first_q && !cnt_max;
  assign cnt_new  = cnt_bump ? cnt_rd + COUNT_W'(1) : cnt_rd;

  always_comb begin
    rd_en     = 1'b0;
    rd_eaddr  = in_eaddr;
    rd_caddr  = in_caddr;
    sum_we    = 1'b0;
    sum_waddr = cur_eaddr;
    sum_wdata = sum_new;
    mean_we   = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = cur_caddr;
    cnt_wdata = cnt_new;
    case (state_q)
      S_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
        sum_wdata = '0;
        cnt_we    = (32'(clr_q) < COUNTS);
        cnt_waddr = clr_q[CNT_AW-1:0];
        cnt_wdata = '0;
      end
      S_IDLE: begin
        mean_we = accept && in_range && (in_data_i.func == FUNC_LOAD);
        rd_en   = start_accum;
      end
      S_ADD: begin
        sum_we = 1'b1;
        cnt_we = cnt_bump;
        // second pass reads the ci entries while the tied ones are written
        if (!phase_q && diff_q) begin
          rd_en    = 1'b1;
          rd_eaddr = ci_eaddr;
          rd_caddr = ci_caddr;
        end
      end
      default: begin
      end
    endcase
  end

  gsa_ram #(.WIDTH(SUM_W), .DEPTH(ELEMS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_eaddr),
    .rdata_o (sum_rd)
  );

  gsa_ram #(.WIDTH(VALUE_W), .DEPTH(ELEMS)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i (in_eaddr),
    .wdata_i (in_data_i.feature_value),
    .re_i    (rd_en),
    .raddr_i (rd_eaddr),
    .rdata_o (mean_rd)
  );

  gsa_ram #(.WIDTH(COUNT_W), .DEPTH(COUNTS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_caddr),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mode_q      <= 1'b0;
      single_q    <= 1'b0;
      tied_q      <= '0;
      ci_q        <= '0;
      strm_q      <= '0;
      comp_q      <= '0;
      x_q         <= '0;
      first_q     <= 1'b0;
      diff_q      <= 1'b0;
      phase_q     <= 1'b0;
      sq_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCUM_MODE:   mode_q   <= cfg_wdata_i[0];
          CFG_SINGLE_STATE: single_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end

      // a result handed over in S_OUT is refilled there instead
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ELEM_AW'(1);
          if (clr_q == ELEM_AW'(ELEMS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_accum) begin
            tied_q  <= s_eff;
            ci_q    <= ci_eff;
            strm_q  <= in_data_i.stream_index;
            comp_q  <= in_data_i.component_index;
            x_q     <= in_data_i.feature_value;
            first_q <= in_data_i.first_component;
            diff_q  <= (ci_eff != s_eff);
            phase_q <= 1'b0;
            res_q   <= '{last_result: in_data_i.last_item, default: '0};
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          sq_q    <= sq_d;
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (!phase_q) begin
            res_q.tied_sum   <= sum_new;
            res_q.tied_count <= cnt_new;
            if (diff_q) begin
              phase_q <= 1'b1;
              state_q <= S_CALC;
            end else begin
              state_q <= S_OUT;
            end
          end else begin
            res_q.ci_sum     <= sum_new;
            res_q.ci_count   <= cnt_new;
            res_q.ci_updated <= 1'b1;
            state_q          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_ci_zero_when_not_updated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ci_updated |-> out_data_o.ci_sum == '0 &&
                                              out_data_o.ci_count == '0)
    else $error("ci fields non-zero without ci update");

  a_add_follows_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD |-> $past(state_q) == S_CALC)
    else $error("write-back without a preceding read cycle");

  a_ci_pass_needs_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD && phase_q |-> diff_q)
    else $error("ci pass on equal states");

  a_var_addend_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD && mode_q |-> !addend[SUM_W-1])
    else $error("negative squared deviation");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && $past(state_q == S_CLEAR) |-> $past(clr_q) == ELEM_AW'(ELEMS - 1))
    else $error("clearing pass ended early");

endmodule
